// File: rtl/core/csf_pkg.sv
// Package of the clause subsumption filter: sequencer states and the result index width.
`timescale 1ns / 1ps
package csf_pkg;

   localparam int INDEX_BITS = 6;

   typedef enum logic [3:0] {
      S_LOAD,
      S_I_START,
      S_I_LEN,
      S_J_START,
      S_J_LEN,
      S_A_FETCH,
      S_A_WAIT,
      S_B_FETCH,
      S_B_CMP,
      S_EMIT
   } state_type;

endpackage

// File: rtl/core/clause_subsumption_filter_core.sv
// Clause subsumption filter: literal store, pairwise subsumption sequencer and verdict output.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | literal, has_literal, end_of_clause,
//           |           |                      | end_of_formula
//   rsp     | out       | rsp_valid/rsp_stall  | clause_index, kept, overflow, last
//
// Items of a formula load at one per cycle into a literal memory with one write and one read port.
// After the formula end the input is stalled while the pass runs; each checked pair
// tests clause a, the shorter clause of the pair (the earlier one on a tie), against the other.
// Verdicts then leave at one per cycle through a registered output stage; rsp_stall
// holds the verdict register and pauses the emission.
// Reset is synchronous and clears control state only; each clause's removed mark is
// kept beside its length and is cleared when the clause is loaded.
`timescale 1ns / 1ps
module clause_subsumption_filter_core #(
   parameter int MAX_CLAUSES    = 64,
   parameter int MAX_CLAUSE_LEN = 16,
   parameter int LITERAL_BITS   = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [LITERAL_BITS-1:0]     req_literal,
   input  logic                        req_has_literal,
   input  logic                        req_end_of_clause,
   input  logic                        req_end_of_formula,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [csf_pkg::INDEX_BITS-1:0] rsp_clause_index,
   output logic                        rsp_kept,
   output logic                        rsp_overflow,
   output logic                        rsp_last
);
   import csf_pkg::*;

   localparam int CW   = $clog2(MAX_CLAUSES);
   localparam int CNTW = $clog2(MAX_CLAUSES + 1);
   localparam int PW   = (MAX_CLAUSE_LEN > 1) ? $clog2(MAX_CLAUSE_LEN) : 1;
   localparam int LW   = $clog2(MAX_CLAUSE_LEN + 1);
   localparam int DEPTH = 2 ** (CW + PW);

   // Each clause word holds its removed mark in the top bit above its length.
   logic [LITERAL_BITS-1:0] store_mem [DEPTH];
   logic [LW:0]             len_mem   [MAX_CLAUSES];

   state_type state_ff, state_in;
   logic [CNTW-1:0] count_ff, count_in, i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [LW-1:0]   fill_ff, fill_in, p_ff, p_in, q_ff, q_in;
   logic [LW-1:0]   len_i_ff, len_i_in, len_j_ff, len_j_in;
   logic            ovf_ff, ovf_in, dir_ff, dir_in;
   logic [LITERAL_BITS-1:0] alit_ff, alit_in, rd_ff;
   logic [LW:0]     len_rd_ff;
   logic            rsp_valid_ff, rsp_valid_in, rsp_kept_ff, rsp_kept_in;
   logic            rsp_ovf_ff, rsp_ovf_in, rsp_last_ff, rsp_last_in;
   logic [INDEX_BITS-1:0] rsp_idx_ff, rsp_idx_in;

   logic            st_we, len_we, accept, closing;
   logic [CW+PW-1:0] st_waddr, st_raddr;
   logic [CW-1:0]   len_waddr, len_raddr, a_idx, b_idx;
   logic [LW-1:0]   len_a, len_b, fill_after;
   logic [LW:0]     len_wdata;
   logic [CNTW-1:0] count_after;

   assign req_stall = (state_ff != S_LOAD);
   assign accept    = req_valid && !req_stall;

   assign a_idx = dir_ff ? j_ff[CW-1:0] : i_ff[CW-1:0];
   assign b_idx = dir_ff ? i_ff[CW-1:0] : j_ff[CW-1:0];
   assign len_a = dir_ff ? len_j_ff : len_i_ff;
   assign len_b = dir_ff ? len_i_ff : len_j_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      dir_in       = dir_ff;
      len_i_in     = len_i_ff;
      len_j_in     = len_j_ff;
      alit_in      = alit_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_idx_in   = rsp_idx_ff;
      rsp_kept_in  = rsp_kept_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      st_we        = 1'b0;
      st_waddr     = {count_ff[CW-1:0], fill_ff[PW-1:0]};
      st_raddr     = {a_idx, p_ff[PW-1:0]};
      len_we       = 1'b0;
      len_waddr    = count_ff[CW-1:0];
      len_wdata    = {1'b0, fill_ff};
      len_raddr    = i_ff[CW-1:0];
      fill_after   = fill_ff;
      count_after  = count_ff;
      closing      = 1'b0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (req_has_literal) begin
                  if (fill_ff < LW'(MAX_CLAUSE_LEN)) begin
                     st_we      = (count_ff < CNTW'(MAX_CLAUSES));
                     fill_after = fill_ff + LW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               closing = req_end_of_clause ||
                         (req_end_of_formula && (req_has_literal || fill_after != '0));
               fill_in = fill_after;
               if (closing) begin
                  if (count_ff < CNTW'(MAX_CLAUSES)) begin
                     len_we      = 1'b1;
                     len_wdata   = {1'b0, fill_after};
                     count_after = count_ff + CNTW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  fill_in = '0;
               end
               count_in = count_after;
               if (req_end_of_formula) begin
                  i_in = '0;
                  if (count_after == '0) begin
                     ovf_in = 1'b0;
                  end else begin
                     state_in = S_I_START;
                  end
               end
            end
         end
         S_I_START: begin
            if (i_ff == count_ff) begin
               k_in      = '0;
               len_raddr = '0;
               state_in  = S_EMIT;
            end else begin
               state_in = S_I_LEN;
            end
         end
         S_I_LEN: begin
            if (len_rd_ff[LW]) begin
               i_in     = i_ff + CNTW'(1);
               state_in = S_I_START;
            end else begin
               len_i_in = len_rd_ff[LW-1:0];
               j_in     = i_ff + CNTW'(1);
               state_in = S_J_START;
            end
         end
         S_J_START: begin
            len_raddr = j_ff[CW-1:0];
            if (j_ff == count_ff) begin
               i_in     = i_ff + CNTW'(1);
               state_in = S_I_START;
            end else begin
               state_in = S_J_LEN;
            end
         end
         S_J_LEN: begin
            if (len_rd_ff[LW]) begin
               j_in     = j_ff + CNTW'(1);
               state_in = S_J_START;
            end else begin
               len_j_in = len_rd_ff[LW-1:0];
               // The shorter clause (the earlier one on a tie) is tested against the other.
               dir_in   = (len_rd_ff[LW-1:0] < len_i_ff);
               p_in     = '0;
               state_in = S_A_FETCH;
            end
         end
         S_A_FETCH: begin
            if (p_ff == len_a) begin
               len_we = 1'b1;
               if (dir_ff) begin
                  len_waddr = i_ff[CW-1:0];
                  len_wdata = {1'b1, len_i_ff};
                  i_in      = i_ff + CNTW'(1);
                  state_in  = S_I_START;
               end else begin
                  len_waddr = j_ff[CW-1:0];
                  len_wdata = {1'b1, len_j_ff};
                  j_in      = j_ff + CNTW'(1);
                  state_in  = S_J_START;
               end
            end else begin
               q_in     = '0;
               state_in = S_A_WAIT;
            end
         end
         S_A_WAIT: begin
            alit_in  = rd_ff;
            state_in = S_B_FETCH;
         end
         S_B_FETCH: begin
            st_raddr = {b_idx, q_ff[PW-1:0]};
            if (q_ff == len_b) begin
               j_in     = j_ff + CNTW'(1);
               state_in = S_J_START;
            end else begin
               state_in = S_B_CMP;
            end
         end
         S_B_CMP: begin
            st_raddr = {b_idx, q_ff[PW-1:0]};
            if (rd_ff == alit_ff) begin
               p_in     = p_ff + LW'(1);
               state_in = S_A_FETCH;
            end else begin
               q_in     = q_ff + LW'(1);
               state_in = S_B_FETCH;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = INDEX_BITS'(k_ff[CW-1:0]);
               rsp_kept_in  = !len_rd_ff[LW];
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = ((k_ff + CNTW'(1)) == count_ff);
               k_in         = k_ff + CNTW'(1);
               if ((k_ff + CNTW'(1)) == count_ff) begin
                  // The whole formula has been reported; get ready for the next one.
                  count_in   = '0;
                  fill_in    = '0;
                  ovf_in     = 1'b0;
                  state_in   = S_LOAD;
               end
            end
            // The mark of the next verdict is read ahead, so its registered copy is ready when it is emitted.
            len_raddr = k_in[CW-1:0];
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         p_ff         <= '0;
         q_ff         <= '0;
         dir_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         p_ff         <= p_in;
         q_ff         <= q_in;
         dir_ff       <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      len_i_ff    <= len_i_in;
      len_j_ff    <= len_j_in;
      alit_ff     <= alit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_kept_ff <= rsp_kept_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= req_literal;
      end
      rd_ff <= store_mem[st_raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_rd_ff <= len_mem[len_raddr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_clause_index = rsp_idx_ff;
   assign rsp_kept         = rsp_kept_ff;
   assign rsp_overflow     = rsp_ovf_ff;
   assign rsp_last         = rsp_last_ff;

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_J_LEN) |-> (j_ff > i_ff))
      else $error("pair scan reached j not above i");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_CLAUSES))
      else $error("clause count beyond store");

   a_pass_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_formula && count_after != '0) |=> (state_ff == S_I_START))
      else $error("formula end did not start the pass");

   a_literal_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_A_FETCH) |-> (p_ff <= len_a))
      else $error("literal position beyond clause length");

endmodule
